// ===== rtl/cik_pkg.sv =====
// package: widths, types and helpers for the coherent intensity kernel
`default_nettype none
package cik_pkg;
  localparam int MaxTerms     = 4;
  localparam int MaxGroups    = 4;
  localparam int DefTerms     = 4;
  localparam int DefGroups    = 4;
  localparam int DefAmpBits   = 18;
  localparam int CoefBits     = 24;
  localparam int RegBits      = 51;
  localparam int WeightBits   = 18;
  localparam int OutBits      = 48;
  localparam int MaxBits      = 47;
  localparam int MagBits      = 40;
  localparam int CfgIdxBits   = 2;
  localparam int SqShift      = 16;
  localparam int WShift       = 15;

  // register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_TERM0 = 2'd0,
    REG_TERM1 = 2'd1,
    REG_TERM2 = 2'd2,
    REG_TERM3 = 2'd3
  } reg_idx_t;

  // per-lane control from the top level
  typedef struct packed {
    logic                enable;
    logic [1:0]          group;
    logic [CoefBits-1:0] coef_re;
    logic [CoefBits-1:0] coef_im;
  } lane_cfg_t;
endpackage
`default_nettype wire

// ===== rtl/cik_lane.sv =====
// one lane: complex coefficient times amplitude, registered
`default_nettype none
module cik_lane
  import cik_pkg::*;
#(
  parameter int AMP_BITS = DefAmpBits,
  parameter int GROUPS   = DefGroups
) (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire lane_cfg_t                  cfg,
  input  wire logic signed [AMP_BITS-1:0] a_re,
  input  wire logic signed [AMP_BITS-1:0] a_im,
  output logic signed [CoefBits+AMP_BITS:0] p_re,
  output logic signed [CoefBits+AMP_BITS:0] p_im,
  output logic [1:0]                        p_group,
  output logic                              p_live
);
  localparam int PW = CoefBits + AMP_BITS;

  logic signed [PW-1:0] rr, ii, ri, ir;
  assign rr = $signed(cfg.coef_re) * a_re;
  assign ii = $signed(cfg.coef_im) * a_im;
  assign ri = $signed(cfg.coef_re) * a_im;
  assign ir = $signed(cfg.coef_im) * a_re;

  // products registered, then combined
  logic signed [PW-1:0] q_rr, q_ii, q_ri, q_ir;
  logic                 q_live;
  logic [1:0]           q_group;
  always_ff @(posedge clk) begin
    if (load) begin
      q_rr    <= rr;
      q_ii    <= ii;
      q_ri    <= ri;
      q_ir    <= ir;
      q_group <= cfg.group;
      q_live  <= cfg.enable && (32'(cfg.group) < GROUPS);
    end
  end

  assign p_re    = {q_rr[PW-1], q_rr} - {q_ii[PW-1], q_ii};
  assign p_im    = {q_ri[PW-1], q_ri} + {q_ir[PW-1], q_ir};
  assign p_group = q_group;
  assign p_live  = q_live;
endmodule
`default_nettype wire

// ===== rtl/cik_merge.sv =====
// merging stage: group sums, rounding, squares, weight and saturation
`default_nettype none
module cik_merge
  import cik_pkg::*;
#(
  parameter int AMP_BITS = DefAmpBits,
  parameter int TERMS    = DefTerms
) (
  input  wire logic                            clk,
  input  wire logic [2:0]                      adv,
  input  wire logic signed [CoefBits+AMP_BITS:0] p_re [TERMS],
  input  wire logic signed [CoefBits+AMP_BITS:0] p_im [TERMS],
  input  wire logic [1:0]                      p_group [TERMS],
  input  wire logic [TERMS-1:0]                p_live,
  input  wire logic signed [WeightBits-1:0]    weight,
  output logic signed [OutBits-1:0]            result
);
  localparam int PW = CoefBits + AMP_BITS + 1;
  localparam int SW = PW + 2;
  localparam int SumShift = AMP_BITS - 3;

  // per-group sums
  logic signed [SW-1:0] gre [MaxGroups];
  logic signed [SW-1:0] gim [MaxGroups];
  always_comb begin
    for (int g = 0; g < MaxGroups; g++) begin
      gre[g] = '0;
      gim[g] = '0;
      for (int k = 0; k < TERMS; k++) begin
        if (p_live[k] && 32'(p_group[k]) == g) begin
          gre[g] = gre[g] + SW'(p_re[k]);
          gim[g] = gim[g] + SW'(p_im[k]);
        end
      end
    end
  end

  function automatic logic [SW-1:0] mag_rnd(input logic signed [SW-1:0] x);
    logic [SW-1:0] m;
    m = x[SW-1] ? SW'(-x) : SW'(x);
    return (m + (SW'(1) << (SumShift - 1))) >> SumShift;
  endfunction

  // stage 1: rounded magnitudes
  logic [31:0] mr [MaxGroups];
  logic [31:0] mi [MaxGroups];
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int g = 0; g < MaxGroups; g++) begin
        mr[g] <= 32'(mag_rnd(gre[g]));
        mi[g] <= 32'(mag_rnd(gim[g]));
      end
    end
  end

  // stage 2: squares summed, rounded to 24 fraction bits
  logic [63:0] power;
  logic [47:0] pw24;
  always_comb begin
    power = '0;
    for (int g = 0; g < MaxGroups; g++) begin
      power = power + {32'd0, mr[g]} * {32'd0, mr[g]} + {32'd0, mi[g]} * {32'd0, mi[g]};
    end
  end
  always_ff @(posedge clk) begin
    if (adv[1]) pw24 <= 48'((power + (64'd1 << (SqShift - 1))) >> SqShift);
  end

  // stage 3: weight product, rounding and saturation
  logic signed [66:0] prod;
  logic [66:0]        pmag, rmag;
  logic signed [66:0] val;
  assign prod = $signed({1'b0, pw24}) * weight;
  assign pmag = prod[66] ? 67'(-prod) : 67'(prod);
  assign rmag = (pmag + (67'd1 << (WShift - 1))) >> WShift;
  assign val  = prod[66] ? -$signed(rmag) : $signed(rmag);
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      if (val > 67'sd140737488355327)       result <= 48'h7FFF_FFFF_FFFF;
      else if (val < -67'sd140737488355328) result <= 48'h8000_0000_0000;
      else                                  result <= val[47:0];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/coherent_intensity_kernel_core.sv =====
// top level: coherent intensity kernel with parallel term lanes
//
// Input channel: amplitudes of all terms, event weight and first_of_batch,
// taken on in_valid & !in_stall. One result beat per event on out_valid /
// out_stall carries intensity and max_so_far.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write the
// four term registers (enable, group, complex coefficient); there are no
// other indexes. cfg_ready is always high; write only while idle.
// Path: each event reaches the result beat through five registers (lane
// products, group rounding, squares, weight product, output register).
// Throughput: one event per cycle; the five-stage pipe advances as a whole
// whenever its output beat is absent or being taken.
// Stall: while a result beat waits on out_stall, in_stall rises and every
// stage keeps its contents, so no beat is lost.
// Reset: clears the configuration registers, the running maximum and all valid bits.
`default_nettype none
module coherent_intensity_kernel_core
  import cik_pkg::*;
#(
  parameter int TERMS    = DefTerms,
  parameter int GROUPS   = DefGroups,
  parameter int AMP_BITS = DefAmpBits
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CfgIdxBits-1:0]        cfg_index,
  input  wire logic [RegBits-1:0]           cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [AMP_BITS-1:0]   amp0_re,
  input  wire logic signed [AMP_BITS-1:0]   amp0_im,
  input  wire logic signed [AMP_BITS-1:0]   amp1_re,
  input  wire logic signed [AMP_BITS-1:0]   amp1_im,
  input  wire logic signed [AMP_BITS-1:0]   amp2_re,
  input  wire logic signed [AMP_BITS-1:0]   amp2_im,
  input  wire logic signed [AMP_BITS-1:0]   amp3_re,
  input  wire logic signed [AMP_BITS-1:0]   amp3_im,
  input  wire logic signed [WeightBits-1:0] event_weight,
  input  wire logic                         first_of_batch,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [OutBits-1:0]         intensity,
  output logic [MaxBits-1:0]                max_so_far
);
  localparam int PW = CoefBits + AMP_BITS + 1;

  // configuration registers
  logic [RegBits-1:0] coef [MaxTerms];
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MaxTerms; k++) coef[k] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TERM0: coef[0] <= cfg_data;
        REG_TERM1: coef[1] <= cfg_data;
        REG_TERM2: coef[2] <= cfg_data;
        REG_TERM3: coef[3] <= cfg_data;
        default:   ;
      endcase
    end
  end

  // pipeline control: stage valids 0..4, whole pipe moves together
  logic [4:0] vld;
  logic       move;
  assign move      = !(vld[4] && out_stall);
  assign in_stall  = !move;
  assign out_valid = vld[4];
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (move) vld <= {vld[3:0], in_valid};
  end

  // side data carried along the pipe
  logic signed [WeightBits-1:0] w_q [3];
  logic                         f_q [4];
  always_ff @(posedge clk) begin
    if (move) begin
      w_q[0] <= event_weight;
      f_q[0] <= first_of_batch;
      for (int s = 1; s < 3; s++) w_q[s] <= w_q[s-1];
      for (int s = 1; s < 4; s++) f_q[s] <= f_q[s-1];
    end
  end

  logic signed [AMP_BITS-1:0] a_re [MaxTerms];
  logic signed [AMP_BITS-1:0] a_im [MaxTerms];
  assign a_re = '{amp0_re, amp1_re, amp2_re, amp3_re};
  assign a_im = '{amp0_im, amp1_im, amp2_im, amp3_im};

  // lanes
  logic signed [PW-1:0] p_re [TERMS];
  logic signed [PW-1:0] p_im [TERMS];
  logic [1:0]           p_group [TERMS];
  logic [TERMS-1:0]     p_live;
  for (genvar k = 0; k < TERMS; k++) begin : g_lane
    lane_cfg_t lc;
    assign lc.enable  = coef[k][50];
    assign lc.group   = coef[k][49:48];
    assign lc.coef_im = coef[k][47:24];
    assign lc.coef_re = coef[k][23:0];
    cik_lane #(.AMP_BITS(AMP_BITS), .GROUPS(GROUPS)) u_lane (
      .clk(clk), .load(move), .cfg(lc), .a_re(a_re[k]), .a_im(a_im[k]),
      .p_re(p_re[k]), .p_im(p_im[k]), .p_group(p_group[k]), .p_live(p_live[k])
    );
  end

  // weight meets the event held in the squares register
  logic signed [OutBits-1:0] res;
  cik_merge #(.AMP_BITS(AMP_BITS), .TERMS(TERMS)) u_merge (
    .clk(clk), .adv({move, move, move}), .p_re(p_re), .p_im(p_im),
    .p_group(p_group), .p_live(p_live), .weight(w_q[2]), .result(res)
  );

  // running maximum and output beat
  logic signed [OutBits-1:0] running_max, base, out_int;
  assign base = f_q[3] ? '0 : running_max;
  always_ff @(posedge clk) begin
    if (rst) running_max <= '0;
    else if (move && vld[3]) begin
      if (res > base) running_max <= res;
      else            running_max <= base;
    end
  end
  always_ff @(posedge clk) begin
    if (move) out_int <= res;
  end
  assign intensity  = out_int;
  assign max_so_far = running_max[MaxBits-1:0];

  // result beat held steady while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(intensity) && $stable(max_so_far));
  // input held off only by a waiting result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall);
  // running maximum never negative
  a_max_floor: assert property (@(posedge clk) disable iff (rst)
    !running_max[OutBits-1]);
  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) rst |=> vld == '0);
endmodule
`default_nettype wire
